FILE: hdl/lroc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lroc_pkg: shared types and codes of the lock rank order checker
// Event and result payloads, action and status codes, cell control structs.
// ----------------------------------------------------------------------------
package lroc_pkg;

  localparam int RANK_W  = 8;
  localparam int DEPTH_W = 4;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_TRY     = 2'd2
  } lroc_action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANK_VIOL = 3'd1,
    ST_NEST_OVF  = 3'd2,
    ST_TRY_BUSY  = 3'd3,
    ST_TRY_RANK  = 3'd4
  } lroc_status_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [RANK_W-1:0] rank;
    logic              lock_busy;
  } lroc_event_t;

  typedef struct packed {
    lroc_status_t       status;
    logic [DEPTH_W-1:0] depth;
    logic [RANK_W-1:0]  top_rank;
  } lroc_result_t;

  // Broadcast to every cell
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              push;
    logic              compact;
  } lroc_bcast_t;

  // Per-cell position decode against the held count
  typedef struct packed {
    logic is_slot;       // cell is the next free entry
    logic is_below_top;  // cell is held and not the top
    logic is_next_top;   // cell sits just below the top
  } lroc_cell_sel_t;

endpackage

FILE: hdl/lroc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lroc_stream_if: valid/ready channel
// Generic payload channel with source and sink views.
// ----------------------------------------------------------------------------
interface lroc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/lock_rank_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_rank_order_checker: per-CPU lock rank stack and ordering check
// One event in, one result out; stack held in a row of rank cells.
// ----------------------------------------------------------------------------
//  channel   | view   | payload                          | transfer when
//  ----------+--------+----------------------------------+----------------
//  in_chan   | sink   | action, rank, lock_busy          | valid && ready
//  out_chan  | source | status, depth, top_rank          | valid && ready
//  cfg_chan  | sink   | panic_bypass (1 bit)             | valid && ready
//
//  Each event is resolved in the cycle of its transfer; its result appears in
//  the output register on the next cycle, so one event per cycle is sustained
//  while each result is taken. The cost per cycle is set by the match and
//  next-top chains through the cells, STACK_DEPTH cells long.
//  Reset (rst_n, synchronous, active low) empties the stack and clears bypass;
//  stack entries themselves are not cleared, no clearing pass.
//  A stalled result holds; in_chan.ready is low only while it is not taken.
// ----------------------------------------------------------------------------
module lock_rank_order_checker #(
  parameter int STACK_DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  lroc_stream_if.sink   in_chan,
  lroc_stream_if.source out_chan,
  lroc_stream_if.sink   cfg_chan
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = lroc_pkg::DEPTH_W;
  localparam int RW = lroc_pkg::RANK_W;

  // architectural state
  logic [CW-1:0]          count_r, count_nxt;
  logic [RW-1:0]          held_top_r, held_top_nxt;
  logic                   bypass_r, bypass_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  lroc_pkg::lroc_result_t out_data_r, out_data_nxt;

  // event decode
  logic                   accept;
  logic                   empty, full, out_of_order, top_match;
  logic                   push, pop, rel;
  logic                   any_match;
  lroc_pkg::lroc_status_t status;
  lroc_pkg::lroc_bcast_t  bcast;
  logic [RW-1:0]          ev_rank;

  // cell chain wiring
  lroc_pkg::lroc_cell_sel_t sel       [STACK_DEPTH];
  logic [RW-1:0]            cell_data [STACK_DEPTH];
  logic                     match_dn  [STACK_DEPTH+1];
  logic [RW-1:0]            ntop_dn   [STACK_DEPTH+1];

  assign ev_rank = in_chan.data.rank;

  // a transfer is taken whenever the result slot is free or being drained
  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign accept         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign empty        = (count_r == '0);
  assign full         = (count_r == CW'(STACK_DEPTH));
  assign out_of_order = !empty && (ev_rank <= held_top_r);
  assign top_match    = !empty && (held_top_r == ev_rank);

  // ---- event resolution -----------------------------------------------------
  always_comb begin
    status = lroc_pkg::ST_OK;
    push   = 1'b0;
    pop    = 1'b0;
    rel    = 1'b0;
    unique case (in_chan.data.action)
      lroc_pkg::ACT_ACQUIRE: begin
        if (!bypass_r) begin
          // order check wins over overflow
          priority if (out_of_order) begin
            status = lroc_pkg::ST_RANK_VIOL;
          end else if (full) begin
            status = lroc_pkg::ST_NEST_OVF;
          end else begin
            push = 1'b1;
          end
        end
      end
      lroc_pkg::ACT_RELEASE: begin
        if (!empty) begin
          if (top_match) begin
            pop = 1'b1;
          end else begin
            rel = 1'b1;  // search below the top; no-op if absent
          end
        end
      end
      lroc_pkg::ACT_TRY: begin
        // a full stack lets a try through without tracking it
        priority if (in_chan.data.lock_busy) begin
          status = lroc_pkg::ST_TRY_BUSY;
        end else if (!full) begin
          if (out_of_order) begin
            status = lroc_pkg::ST_TRY_RANK;
          end else begin
            push = 1'b1;
          end
        end
      end
      default: begin
        // unused action code: ignored
      end
    endcase
  end

  assign bcast.rank    = ev_rank;
  assign bcast.push    = accept && push;
  assign bcast.compact = accept && rel && any_match;

  // ---- cell row ---------------------------------------------------------------
  // Chains run from the top cell down to cell 0: match_dn carries "a match
  // sits above", ntop_dn collects the entry just below the top.
  assign match_dn[STACK_DEPTH] = 1'b0;
  assign ntop_dn[STACK_DEPTH]  = '0;
  assign any_match             = match_dn[0];

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    assign sel[g].is_slot      = (int'(count_r) == g);
    assign sel[g].is_below_top = ((g + 1) < int'(count_r));
    assign sel[g].is_next_top  = ((g + 2) == int'(count_r));

    lroc_cell u_cell (
      .clk           (clk),
      .bcast         (bcast),
      .sel           (sel[g]),
      .up_data_i     ((g == STACK_DEPTH - 1) ? '0 : cell_data[(g + 1) % STACK_DEPTH]),
      .match_above_i (match_dn[g+1]),
      .match_above_o (match_dn[g]),
      .next_top_i    (ntop_dn[g+1]),
      .next_top_o    (ntop_dn[g]),
      .data_o        (cell_data[g])
    );
  end

  // ---- next state -------------------------------------------------------------
  always_comb begin
    count_nxt    = count_r;
    held_top_nxt = held_top_r;
    if (accept) begin
      priority if (push) begin
        count_nxt    = count_r + CW'(1);
        held_top_nxt = ev_rank;
      end else if (pop) begin
        count_nxt    = count_r - CW'(1);
        held_top_nxt = ntop_dn[0];  // zero when the stack empties
      end else if (bcast.compact) begin
        count_nxt    = count_r - CW'(1);  // top value is unchanged
      end else begin
        count_nxt    = count_r;
      end
    end
  end

  assign bypass_nxt = cfg_chan.valid ? cfg_chan.data : bypass_r;

  always_comb begin
    out_valid_nxt         = out_valid_r && !out_chan.ready;
    out_data_nxt          = out_data_r;
    if (accept) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.status   = status;
      out_data_nxt.depth    = DW'(count_nxt);
      out_data_nxt.top_rank = held_top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      held_top_r  <= '0;
      bypass_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      held_top_r  <= held_top_nxt;
      bypass_r    <= bypass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= STACK_DEPTH)
    else $error("held count beyond stack depth");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (held_top_r == '0))
    else $error("top rank not zero on empty stack");

  a_step_one: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1))
               || (count_r + CW'(1) == $past(count_r)))
    else $error("held count moved by more than one");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r) && $stable(held_top_r))
    else $error("stack state changed without a transfer");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && (out_data_r.top_rank == held_top_r))
    else $error("result missing or top rank mismatch");
`endif

endmodule

FILE: hdl/lroc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lroc_cell: one entry of the rank stack
// Holds one rank, takes a push or its upper neighbour's rank on compaction,
// and forwards the match and next-top chains downward.
// ----------------------------------------------------------------------------
module lroc_cell (
  input  logic                            clk,
  input  lroc_pkg::lroc_bcast_t           bcast,
  input  lroc_pkg::lroc_cell_sel_t        sel,
  input  logic [lroc_pkg::RANK_W-1:0]     up_data_i,
  input  logic                            match_above_i,
  output logic                            match_above_o,
  input  logic [lroc_pkg::RANK_W-1:0]     next_top_i,
  output logic [lroc_pkg::RANK_W-1:0]     next_top_o,
  output logic [lroc_pkg::RANK_W-1:0]     data_o
);

  logic [lroc_pkg::RANK_W-1:0] data_r;
  logic [lroc_pkg::RANK_W-1:0] data_nxt;
  logic                        match;
  logic                        shift;

  assign match         = sel.is_below_top && (data_r == bcast.rank);
  assign match_above_o = match_above_i | match;
  // at or above the uppermost match, below the top
  assign shift         = bcast.compact && sel.is_below_top && !match_above_i;
  assign next_top_o    = next_top_i | (sel.is_next_top ? data_r : '0);
  assign data_o        = data_r;

  always_comb begin
    priority if (bcast.push && sel.is_slot) begin
      data_nxt = bcast.rank;
    end else if (shift) begin
      data_nxt = up_data_i;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
